// File: src/bftt_pkg.sv
// Shared types, constants and helpers for the bidirectional flow tag table.
// Used by bftt_cell, bftt_select and bidirectional_flow_tag_table_core.
package bftt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_BITS   = 32;
  localparam int IN_ADDR_W   = 32;
  localparam int PORT_W      = 16;
  localparam int TAG_W       = 16;
  localparam int CNT_OUT_W   = 7;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int GRP_SIZE    = 8;
  localparam int NGRP        = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FIND  = 2'd1,
    MODE_DEL   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL1,
    ST_SEL2,
    ST_ACT,
    ST_SHIFT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [PORT_W-1:0]    sport;
    logic [PORT_W-1:0]    dport;
    logic [TAG_W-1:0]     tag;
  } entry_t;

  // What one cell hands to the cell below it during a compaction shift.
  typedef struct packed {
    logic   valid;
    logic   kill;
    entry_t data;
  } cell_link_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    entry_t key;
    logic   cmp;
    logic   shift_en;
    logic   clear;
  } cell_ctl_t;

  function automatic logic port_ok(input logic [PORT_W-1:0] a,
                                   input logic [PORT_W-1:0] b);
    return (a == '0) || (b == '0) || (a == b);
  endfunction

endpackage

// File: src/bidirectional_flow_tag_table_core.sv
// Top level of the bidirectional flow tag table: sequencer, cell row and
// newest-match tree. Uses bftt_pkg, bftt_cell and bftt_select.
//
// Usage:
//   Input channel (in_*): one request word per handshake: mode, address
//   pair, port pair and a tag for add. A word is taken when in_valid is
//   high and in_stall is low; in_stall is high while a request is in work.
//   Result channel (out_*): one result word per request: status, hit,
//   tag_out, removed and entry_count, taken when out_valid is high and
//   out_stall is low.
//   Add, find and clear pass from acceptance to the result register
//   through one compare step in the cells, the two stages of the
//   newest-match tree, one action step and one load step. Delete adds a
//   compaction phase after the action step: the cell row compacts by one
//   slot per cycle until no slot is marked. A new request is accepted in
//   the cycle after the result is loaded, even if that result still
//   waits.
//   The result register holds its word while out_stall is high; the
//   sequencer waits for it to drain before loading the next result.
//   Reset (synchronous, rst_n low) empties the table and drops any request
//   in work; slot contents other than the valid, kill and match flags are not cleared.
module bidirectional_flow_tag_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_sport,
  input  logic [15:0] in_dport,
  input  logic [15:0] in_tag_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic [15:0] out_tag_out,
  output logic [6:0]  out_removed,
  output logic [6:0]  out_entry_count
);
  import bftt_pkg::*;

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  entry_t           key_r, key_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rm_r, rm_nxt;
  status_t          status_r, status_nxt;
  logic             hit_r, hit_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r;
  logic                 out_hit_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [CNT_OUT_W-1:0] out_removed_r, out_count_r;
  logic                 out_load;

  cell_ctl_t        ctl;
  logic             do_write;
  cell_link_t       link [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0]   shc;
  logic [TABLE_DEPTH-1:0] match_vec, valid_vec, kill_vec, wr_vec;
  logic [TAG_W-1:0] tag_arr [TABLE_DEPTH];
  logic             any_kill;
  logic             sel_hit;
  logic [TAG_W-1:0] sel_tag;

  assign link[TABLE_DEPTH] = '0;
  assign shc[0]            = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign wr_vec[i]    = do_write && (count_r == CNT_W'(i));
    assign valid_vec[i] = link[i].valid;
    assign kill_vec[i]  = link[i].kill;
    assign tag_arr[i]   = link[i].data.tag;

    bftt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr        (wr_vec[i]),
      .up        (link[i+1]),
      .shift_in  (shc[i]),
      .shift_out (shc[i+1]),
      .own       (link[i]),
      .match     (match_vec[i])
    );
  end

  assign any_kill = |kill_vec;

  bftt_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .match_vec (match_vec),
    .tag_arr   (tag_arr),
    .sel_hit   (sel_hit),
    .sel_tag   (sel_tag)
  );

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    count_nxt    = count_r;
    rm_nxt       = rm_r;
    status_nxt   = status_r;
    hit_nxt      = hit_r;
    tag_nxt      = tag_r;
    ctl.key      = key_r;
    ctl.cmp      = 1'b0;
    ctl.shift_en = 1'b0;
    ctl.clear    = 1'b0;
    do_write     = 1'b0;
    in_stall     = (state_r != ST_IDLE);
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt         = mode_t'(in_mode);
          key_nxt.src_addr = ADDR_BITS'(in_src_addr);
          key_nxt.dst_addr = ADDR_BITS'(in_dst_addr);
          key_nxt.sport    = in_sport;
          key_nxt.dport    = in_dport;
          key_nxt.tag      = in_tag_in;
          rm_nxt           = '0;
          status_nxt       = STAT_DONE;
          hit_nxt          = 1'b0;
          tag_nxt          = '0;
          state_nxt        = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = ST_SEL1;
      end
      ST_SEL1: state_nxt = ST_SEL2;
      ST_SEL2: state_nxt = ST_ACT;
      ST_ACT: begin
        state_nxt = ST_FIN;
        unique case (mode_r)
          MODE_ADD: begin
            if (sel_hit) begin
              status_nxt = STAT_DUP;
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              status_nxt = STAT_FULL;
            end else begin
              do_write  = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          MODE_FIND: begin
            hit_nxt = sel_hit;
            tag_nxt = sel_hit ? sel_tag : '0;
          end
          MODE_DEL: state_nxt = ST_SHIFT;
          MODE_CLEAR: begin
            ctl.clear = 1'b1;
            rm_nxt    = count_r;
            count_nxt = '0;
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_SHIFT: begin
        // drop the lowest marked slot each cycle until none is left
        if (any_kill) begin
          ctl.shift_en = 1'b1;
          count_nxt    = count_r - 1'b1;
          rm_nxt       = rm_r + 1'b1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    rm_r     <= rm_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    tag_r    <= tag_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_hit_r     <= hit_r;
      out_tag_r     <= tag_r;
      out_removed_r <= CNT_OUT_W'(rm_r);
      out_count_r   <= CNT_OUT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit         = out_hit_r;
  assign out_tag_out     = out_tag_r;
  assign out_removed     = out_removed_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("valid slots disagree with entry count");

  a_shift_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && any_kill) |=> (count_r == $past(count_r) - 1'b1))
    else $error("compaction step did not drop one entry");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACT && mode_r == MODE_CLEAR) |=> (valid_vec == '0))
    else $error("clear left valid slots");
`endif

endmodule

// File: src/bftt_cell.sv
// One table slot: holds an entry, compares it against the request key and
// shifts down from its upper neighbor during delete compaction. Uses bftt_pkg.
module bftt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bftt_pkg::cell_ctl_t ctl,
  input  logic                wr,
  input  bftt_pkg::cell_link_t up,
  input  logic                shift_in,
  output logic                shift_out,
  output bftt_pkg::cell_link_t own,
  output logic                match
);
  import bftt_pkg::*;

  logic   valid_r;
  logic   kill_r;
  logic   match_r;
  entry_t data_r;
  logic   fwd, rev, pair, take;

  // A cell moves down once any slot at or below it is marked for removal.
  assign shift_out = shift_in | kill_r;
  assign take      = ctl.shift_en & shift_out;

  always_comb begin
    fwd  = (data_r.src_addr == ctl.key.src_addr) && (data_r.dst_addr == ctl.key.dst_addr) &&
           port_ok(ctl.key.sport, data_r.sport) &&
           port_ok(ctl.key.dport, data_r.dport);
    rev  = (data_r.dst_addr == ctl.key.src_addr) && (data_r.src_addr == ctl.key.dst_addr) &&
           port_ok(ctl.key.sport, data_r.dport) &&
           port_ok(ctl.key.dport, data_r.sport);
    pair = ((data_r.src_addr == ctl.key.src_addr) && (data_r.dst_addr == ctl.key.dst_addr)) ||
           ((data_r.dst_addr == ctl.key.src_addr) && (data_r.src_addr == ctl.key.dst_addr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      kill_r  <= 1'b0;
      match_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
      kill_r  <= 1'b0;
    end else if (take) begin
      valid_r <= up.valid;
      kill_r  <= up.kill;
    end else if (wr) begin
      valid_r <= 1'b1;
      kill_r  <= 1'b0;
    end else if (ctl.cmp) begin
      match_r <= valid_r & (fwd | rev);
      kill_r  <= valid_r & pair;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= up.data;
    end else if (wr) begin
      data_r <= ctl.key;
    end
  end

  assign own.valid = valid_r;
  assign own.kill  = kill_r;
  assign own.data  = data_r;
  assign match     = match_r;

endmodule

// File: src/bftt_select.sv
// Two-stage registered tree that picks the newest matching slot and its tag.
// Uses bftt_pkg; fed by the cell row in the core.
module bftt_select (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bftt_pkg::TABLE_DEPTH-1:0] match_vec,
  input  logic [bftt_pkg::TAG_W-1:0] tag_arr [bftt_pkg::TABLE_DEPTH],
  output logic                       sel_hit,
  output logic [bftt_pkg::TAG_W-1:0] sel_tag
);
  import bftt_pkg::*;

  logic [NGRP*GRP_SIZE-1:0] match_pad;
  logic [TAG_W-1:0]         tag_pad [NGRP*GRP_SIZE];
  logic [NGRP-1:0]          grp_hit_nxt, grp_hit_r;
  logic [TAG_W-1:0]         grp_tag_nxt [NGRP];
  logic [TAG_W-1:0]         grp_tag_r   [NGRP];
  logic                     hit_nxt, hit_r;
  logic [TAG_W-1:0]         tag_nxt, tag_r;

  always_comb begin
    match_pad = '0;
    match_pad[TABLE_DEPTH-1:0] = match_vec;
    for (int i = 0; i < NGRP*GRP_SIZE; i++) begin
      tag_pad[i] = (i < TABLE_DEPTH) ? tag_arr[i] : '0;
    end
  end

  // Stage one: newest match inside each group (higher slot wins).
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_tag_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (match_pad[g*GRP_SIZE + j]) begin
          grp_hit_nxt[g] = 1'b1;
          grp_tag_nxt[g] = tag_pad[g*GRP_SIZE + j];
        end
      end
    end
  end

  // Stage two: newest group with a match.
  always_comb begin
    hit_nxt = 1'b0;
    tag_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_hit_r[g]) begin
        hit_nxt = 1'b1;
        tag_nxt = grp_tag_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_hit_r <= '0;
      hit_r     <= 1'b0;
    end else begin
      grp_hit_r <= grp_hit_nxt;
      hit_r     <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_tag_r <= grp_tag_nxt;
    tag_r     <= tag_nxt;
  end

  assign sel_hit = hit_r;
  assign sel_tag = tag_r;

endmodule
